/* src/cbts_pkg.sv */
`default_nettype none
package cbts_pkg;

    localparam int VAL_W     = 32;
    localparam int W_W       = 40;
    localparam int ND_W      = 42;
    localparam int FRAC_BITS = 30;

    localparam logic [2:0] REG_LOW  = 3'd0;
    localparam logic [2:0] REG_HIGH = 3'd1;
    localparam logic [2:0] REG_CNT  = 3'd2;
    localparam logic [2:0] REG_ZEN  = 3'd3;
    localparam logic [2:0] REG_THR  = 3'd4;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
        logic signed [VAL_W-1:0] u;
    } t_vtx;

endpackage
`default_nettype wire

/* src/contour_band_triangle_splitter.sv */
`default_nettype none
// Steps: band lookup for each of the three vertices, then per edge cut up to a 30-step
// restoring divide and multiplies in cbts_edge; one vertex per cycle unless i_stall holds it.
// One triangle at a time; the input is stalled until its last vertex is in the output register.
// Reset: synchronous, active low; clears the sequencer and loads register defaults.
module contour_band_triangle_splitter
    import cbts_pkg::*;
#(
    parameter int MAX_BANDS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_aval,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by_coord,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_bval,
    input  logic signed [31:0] i_cx_coord,
    input  logic signed [31:0] i_cy_coord,
    input  logic signed [31:0] i_cz_coord,
    input  logic signed [31:0] i_cval,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [3:0]         o_band,
    output logic               o_prim_kind,
    output logic               o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_BAND_INIT, S_BAND_RUN, S_SORT, S_DISPATCH,
        S_SPLIT_WAIT, S_CUT_SETUP, S_CUT_WAIT, S_EMIT
    } t_state;

    typedef enum logic [1:0] {PH_SINGLE, PH_HEAD, PH_MID, PH_TAIL} t_phase;

    typedef enum logic [2:0] {SEL_P0, SEL_P1, SEL_P2, SEL_TA, SEL_TB, SEL_NA, SEL_NB} t_sel;

    localparam logic [3:0] MAXB = 4'(MAX_BANDS);

    logic signed [31:0] r_low;
    logic signed [31:0] r_high;
    logic [3:0]         r_count;
    logic               r_zen;
    logic [30:0]        r_thr;

    t_state             r_st;
    t_vtx               r_v [3];
    logic [3:0]         r_c [3];
    logic [1:0]         r_bi;
    logic signed [37:0] r_dn;
    logic signed [37:0] r_acc;
    logic [3:0]         r_k;
    logic               r_bzero;
    t_vtx               r_p [3];
    t_vtx               r_ta;
    t_vtx               r_tb;
    t_vtx               r_na;
    t_vtx               r_nb;
    t_vtx               r_s;
    logic [3:0]         r_col;
    logic [3:0]         r_fin;
    logic [3:0]         r_m;
    logic               r_hmode;
    logic               r_last_part;
    logic               r_edge_b;
    logic               r_to_n;
    t_phase             r_phase;
    logic [2:0]         r_idx;
    t_vtx               r_ep;
    t_vtx               r_eq;
    logic signed [W_W-1:0] r_w;
    logic [3:0]         r_escale;
    logic               r_estart;
    logic               r_ov;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic signed [31:0] r_oz;
    logic [3:0]         r_oband;
    logic               r_okind;
    logic               r_olast;

    logic [3:0]         n_eff;
    logic signed [32:0] span;
    logic signed [32:0] d;
    logic signed [37:0] dn;
    logic signed [36:0] low_n;
    logic signed [37:0] span_m;
    logic signed [W_W-1:0] w_cut;
    logic [1:0]         mi;
    t_vtx               rot [3];
    logic [3:0]         rot_c [3];
    t_vtx               srt [3];
    logic [3:0]         srt_c [3];
    t_sel               em_sel;
    logic [2:0]         em_len;
    logic               em_kind;
    t_vtx               em_v;
    logic               emit_ok;
    logic               e_done;
    t_vtx               e_pt;
    t_vtx               s_full;

    function automatic logic signed [31:0] zap(input logic signed [31:0] u,
                                               input logic en, input logic [30:0] thr);
        logic [32:0] mag;
        begin
            mag = u[31] ? (33'd0 - {u[31], u}) : {u[31], u};
            zap = (en && mag < {2'b00, thr}) ? 32'sd0 : u;
        end
    endfunction

    always_comb begin
        if (r_count == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_count > MAXB) begin
            n_eff = MAXB;
        end else begin
            n_eff = r_count;
        end
    end

    assign span   = {r_high[31], r_high} - {r_low[31], r_low};
    assign d      = {r_v[r_bi].u[31], r_v[r_bi].u} - {r_low[31], r_low};
    assign dn     = d * $signed({1'b0, n_eff});
    assign low_n  = r_low * $signed({1'b0, n_eff});
    assign span_m = span * $signed({1'b0, r_m});
    assign w_cut  = W_W'(low_n) + W_W'(span_m);

    always_comb begin
        mi = (r_v[1].u < r_v[0].u) ? 2'd1 : 2'd0;
        if (r_v[2].u < r_v[mi].u) begin
            mi = 2'd2;
        end
        case (mi)
            2'd1: begin
                rot[0] = r_v[1]; rot[1] = r_v[2]; rot[2] = r_v[0];
                rot_c[0] = r_c[1]; rot_c[1] = r_c[2]; rot_c[2] = r_c[0];
            end
            2'd2: begin
                rot[0] = r_v[2]; rot[1] = r_v[0]; rot[2] = r_v[1];
                rot_c[0] = r_c[2]; rot_c[1] = r_c[0]; rot_c[2] = r_c[1];
            end
            default: begin
                rot[0] = r_v[0]; rot[1] = r_v[1]; rot[2] = r_v[2];
                rot_c[0] = r_c[0]; rot_c[1] = r_c[1]; rot_c[2] = r_c[2];
            end
        endcase
        srt[0] = rot[0];
        srt_c[0] = rot_c[0];
        if (rot[2].u < rot[1].u) begin
            srt[1] = rot[2]; srt[2] = rot[1];
            srt_c[1] = rot_c[2]; srt_c[2] = rot_c[1];
        end else begin
            srt[1] = rot[1]; srt[2] = rot[2];
            srt_c[1] = rot_c[1]; srt_c[2] = rot_c[2];
        end
    end

    always_comb begin
        em_sel  = SEL_P0;
        em_len  = 3'd4;
        em_kind = 1'b1;
        case (r_phase)
            PH_SINGLE: begin
                em_len  = 3'd3;
                em_kind = 1'b0;
                case (r_idx)
                    3'd0:    em_sel = SEL_P0;
                    3'd1:    em_sel = SEL_P1;
                    default: em_sel = SEL_P2;
                endcase
            end
            PH_HEAD: begin
                if (r_hmode) begin
                    case (r_idx)
                        3'd0:    em_sel = SEL_P0;
                        3'd1:    em_sel = SEL_P1;
                        3'd2:    em_sel = SEL_TB;
                        default: em_sel = SEL_TA;
                    endcase
                end else begin
                    em_len  = 3'd3;
                    em_kind = 1'b0;
                    case (r_idx)
                        3'd0:    em_sel = SEL_P0;
                        3'd1:    em_sel = SEL_TB;
                        default: em_sel = SEL_TA;
                    endcase
                end
            end
            PH_MID: begin
                case (r_idx)
                    3'd0:    em_sel = SEL_TA;
                    3'd1:    em_sel = SEL_TB;
                    3'd2:    em_sel = SEL_NB;
                    default: em_sel = SEL_NA;
                endcase
            end
            default: begin
                if (r_hmode) begin
                    em_len  = 3'd3;
                    em_kind = 1'b0;
                end
                case (r_idx)
                    3'd0:    em_sel = SEL_TA;
                    3'd1:    em_sel = SEL_TB;
                    3'd2:    em_sel = SEL_P2;
                    default: em_sel = SEL_P1;
                endcase
            end
        endcase
        case (em_sel)
            SEL_P0:  em_v = r_p[0];
            SEL_P1:  em_v = r_p[1];
            SEL_P2:  em_v = r_p[2];
            SEL_TA:  em_v = r_ta;
            SEL_TB:  em_v = r_tb;
            SEL_NA:  em_v = r_na;
            SEL_NB:  em_v = r_nb;
            default: em_v = r_p[0];
        endcase
    end

    assign emit_ok = (r_st == S_EMIT) && (!r_ov || !i_stall);

    always_comb begin
        s_full   = e_pt;
        s_full.u = r_v[1].u;
    end

    cbts_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_estart),
        .i_p     (r_ep),
        .i_q     (r_eq),
        .i_w     (r_w),
        .i_scale (r_escale),
        .o_done  (e_done),
        .o_pt    (e_pt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= 32'sd0;
            r_high  <= 32'sd65536;
            r_count <= 4'd12;
            r_zen   <= 1'b0;
            r_thr   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW:  r_low   <= i_cfg_data;
                REG_HIGH: r_high  <= i_cfg_data;
                REG_CNT:  r_count <= i_cfg_data[3:0];
                REG_ZEN:  r_zen   <= i_cfg_data[0];
                REG_THR:  r_thr   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_estart <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_estart <= 1'b0;
            if (emit_ok) begin
                r_ov    <= 1'b1;
                r_ox    <= em_v.x;
                r_oy    <= em_v.y;
                r_oz    <= em_v.z;
                r_oband <= (r_phase == PH_TAIL) ? r_fin : r_col;
                r_okind <= em_kind;
                r_olast <= (r_phase == PH_SINGLE || r_phase == PH_TAIL) && r_last_part &&
                           (r_idx == em_len - 3'd1);
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v[0] <= '{x: i_ax, y: i_ay, z: i_az, u: zap(i_aval, r_zen, r_thr)};
                        r_v[1] <= '{x: i_bx, y: i_by_coord, z: i_bz,
                                    u: zap(i_bval, r_zen, r_thr)};
                        r_v[2] <= '{x: i_cx_coord, y: i_cy_coord, z: i_cz_coord,
                                    u: zap(i_cval, r_zen, r_thr)};
                        r_bi   <= 2'd0;
                        r_st   <= S_BAND_INIT;
                    end
                end
                S_BAND_INIT: begin
                    r_dn    <= dn;
                    r_acc   <= 38'(span);
                    r_k     <= 4'd0;
                    r_bzero <= (span <= 0) || (d < 0);
                    r_st    <= S_BAND_RUN;
                end
                S_BAND_RUN: begin
                    if (r_bzero || r_k == n_eff - 4'd1 || r_dn < r_acc) begin
                        r_c[r_bi] <= r_bzero ? 4'd0 : r_k;
                        if (r_bi == 2'd2) begin
                            r_st <= S_SORT;
                        end else begin
                            r_bi <= r_bi + 2'd1;
                            r_st <= S_BAND_INIT;
                        end
                    end else begin
                        r_k   <= r_k + 4'd1;
                        r_acc <= r_acc + 38'(span);
                    end
                end
                S_SORT: begin
                    if (r_c[0] == r_c[1] && r_c[1] == r_c[2]) begin
                        r_p         <= r_v;
                        r_phase     <= PH_SINGLE;
                        r_col       <= r_c[0];
                        r_last_part <= 1'b1;
                        r_idx       <= 3'd0;
                        r_st        <= S_EMIT;
                    end else begin
                        r_v  <= srt;
                        r_c  <= srt_c;
                        r_st <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_edge_b <= 1'b0;
                    r_to_n   <= 1'b0;
                    r_col    <= r_c[0];
                    r_m      <= r_c[0] + 4'd1;
                    r_last_part <= 1'b1;
                    if (r_c[0] != r_c[1] && r_c[1] != r_c[2]) begin
                        r_ep     <= r_v[0];
                        r_eq     <= r_v[2];
                        r_w      <= W_W'(r_v[1].u);
                        r_escale <= 4'd1;
                        r_estart <= 1'b1;
                        r_st     <= S_SPLIT_WAIT;
                    end else if (r_c[0] != r_c[1]) begin
                        r_p[0]  <= r_v[0];
                        r_p[1]  <= r_v[2];
                        r_p[2]  <= r_v[1];
                        r_hmode <= 1'b0;
                        r_fin   <= r_c[1];
                        r_st    <= S_CUT_SETUP;
                    end else if (r_c[1] != r_c[2]) begin
                        r_p     <= r_v;
                        r_hmode <= 1'b1;
                        r_fin   <= r_c[2];
                        r_st    <= S_CUT_SETUP;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_SPLIT_WAIT: begin
                    if (e_done) begin
                        r_s         <= s_full;
                        r_p[0]      <= r_v[0];
                        r_p[1]      <= s_full;
                        r_p[2]      <= r_v[1];
                        r_hmode     <= 1'b0;
                        r_fin       <= r_c[1];
                        r_last_part <= 1'b0;
                        r_st        <= S_CUT_SETUP;
                    end
                end
                S_CUT_SETUP: begin
                    r_ep     <= (r_edge_b && r_hmode) ? r_p[1] : r_p[0];
                    r_eq     <= (r_edge_b || r_hmode) ? r_p[2] : r_p[1];
                    r_w      <= w_cut;
                    r_escale <= n_eff;
                    r_estart <= 1'b1;
                    r_st     <= S_CUT_WAIT;
                end
                S_CUT_WAIT: begin
                    if (e_done) begin
                        case ({r_to_n, r_edge_b})
                            2'b00:   r_ta <= e_pt;
                            2'b01:   r_tb <= e_pt;
                            2'b10:   r_na <= e_pt;
                            default: r_nb <= e_pt;
                        endcase
                        if (!r_edge_b) begin
                            r_edge_b <= 1'b1;
                            r_st     <= S_CUT_SETUP;
                        end else begin
                            r_phase <= r_to_n ? PH_MID : PH_HEAD;
                            r_idx   <= 3'd0;
                            r_st    <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        if (r_idx == em_len - 3'd1) begin
                            r_idx <= 3'd0;
                            case (r_phase)
                                PH_HEAD, PH_MID: begin
                                    if (r_phase == PH_MID) begin
                                        r_ta <= r_na;
                                        r_tb <= r_nb;
                                    end
                                    r_col <= r_col + 4'd1;
                                    if (r_col + 4'd1 < r_fin) begin
                                        r_m      <= r_col + 4'd2;
                                        r_edge_b <= 1'b0;
                                        r_to_n   <= 1'b1;
                                        r_st     <= S_CUT_SETUP;
                                    end else begin
                                        r_phase <= PH_TAIL;
                                    end
                                end
                                PH_TAIL: begin
                                    if (r_last_part) begin
                                        r_st <= S_IDLE;
                                    end else begin
                                        r_p[0]      <= r_s;
                                        r_p[1]      <= r_v[1];
                                        r_p[2]      <= r_v[2];
                                        r_hmode     <= 1'b1;
                                        r_col       <= r_c[1];
                                        r_fin       <= r_c[2];
                                        r_m         <= r_c[1] + 4'd1;
                                        r_last_part <= 1'b1;
                                        r_edge_b    <= 1'b0;
                                        r_to_n      <= 1'b0;
                                        r_st        <= S_CUT_SETUP;
                                    end
                                end
                                default: r_st <= S_IDLE;
                            endcase
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_st != S_IDLE);
    assign o_valid     = r_ov;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_band      = r_oband;
    assign o_prim_kind = r_okind;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

/* src/cbts_edge.sv */
`default_nettype none
module cbts_edge
    import cbts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_vtx                  i_p,
    input  t_vtx                  i_q,
    input  logic signed [W_W-1:0] i_w,
    input  logic [3:0]            i_scale,
    output logic                  o_done,
    output t_vtx                  o_pt
);

    typedef enum logic [2:0] {
        E_IDLE, E_SCALE, E_SIGN, E_CLAMP, E_DIV, E_MUL0, E_MUL1, E_MUL2
    } t_estate;

    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    t_estate                 r_st;
    logic signed [ND_W-1:0]  r_num;
    logic signed [ND_W-1:0]  r_den;
    logic [ND_W-1:0]         r_rem;
    logic [FRAC_BITS:0]      r_a;
    logic [4:0]              r_cnt;
    logic [1:0]              r_k;
    logic signed [49:0]      r_prod;
    logic signed [63:0]      r_acc;
    t_vtx                    r_pt;
    logic                    r_done;

    logic signed [36:0]      pu_sc;
    logic signed [32:0]      du;
    logic signed [37:0]      den_sc;
    logic signed [ND_W-1:0]  num0;
    logic signed [31:0]      p_c;
    logic signed [31:0]      q_c;
    logic signed [32:0]      diff;
    logic signed [49:0]      prod_lo;
    logic signed [49:0]      prod_hi;
    logic [ND_W-1:0]         rem2;
    logic signed [63:0]      sum;
    logic signed [63:0]      rnd;
    logic signed [31:0]      c_new;

    assign pu_sc   = i_p.u * $signed({1'b0, i_scale});
    assign du      = {i_q.u[31], i_q.u} - {i_p.u[31], i_p.u};
    assign den_sc  = du * $signed({1'b0, i_scale});
    assign num0    = ND_W'(i_w) - ND_W'(pu_sc);

    always_comb begin
        case (r_k)
            2'd0: begin
                p_c = i_p.x;
                q_c = i_q.x;
            end
            2'd1: begin
                p_c = i_p.y;
                q_c = i_q.y;
            end
            default: begin
                p_c = i_p.z;
                q_c = i_q.z;
            end
        endcase
    end

    assign diff    = {q_c[31], q_c} - {p_c[31], p_c};
    assign prod_lo = diff * $signed({1'b0, r_a[15:0]});
    assign prod_hi = diff * $signed({1'b0, r_a[30:16]});
    assign rem2    = {r_rem[ND_W-2:0], 1'b0};
    assign sum     = r_acc + (64'(r_prod) <<< 16);
    assign rnd     = sum >>> FRAC_BITS;
    assign c_new   = p_c + rnd[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                E_IDLE: begin
                    r_pt.u <= '0;
                    if (i_start) begin
                        r_st <= E_SCALE;
                    end
                end
                E_SCALE: begin
                    r_num <= num0;
                    r_den <= ND_W'(den_sc);
                    r_st  <= E_SIGN;
                end
                E_SIGN: begin
                    if (r_den < 0) begin
                        r_num <= -r_num;
                        r_den <= -r_den;
                    end
                    r_st <= E_CLAMP;
                end
                E_CLAMP: begin
                    r_a   <= '0;
                    r_k   <= 2'd0;
                    r_cnt <= '0;
                    r_rem <= r_num;
                    if (r_den == 0 || r_num < 0) begin
                        r_st <= E_MUL0;
                    end else if (r_num >= r_den) begin
                        r_a  <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                        r_st <= E_MUL0;
                    end else begin
                        r_st <= E_DIV;
                    end
                end
                E_DIV: begin
                    if (rem2 >= $unsigned(r_den)) begin
                        r_rem <= rem2 - $unsigned(r_den);
                        r_a   <= {r_a[FRAC_BITS-1:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_a   <= {r_a[FRAC_BITS-1:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(FRAC_BITS - 1)) begin
                        r_st <= E_MUL0;
                    end
                end
                E_MUL0: begin
                    r_prod <= prod_lo;
                    r_st   <= E_MUL1;
                end
                E_MUL1: begin
                    r_acc  <= 64'(r_prod) + RND_HALF;
                    r_prod <= prod_hi;
                    r_st   <= E_MUL2;
                end
                E_MUL2: begin
                    case (r_k)
                        2'd0:    r_pt.x <= c_new;
                        2'd1:    r_pt.y <= c_new;
                        default: r_pt.z <= c_new;
                    endcase
                    if (r_k == 2'd2) begin
                        r_done <= 1'b1;
                        r_st   <= E_IDLE;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_st <= E_MUL0;
                    end
                end
                default: r_st <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_pt   = r_pt;

endmodule
`default_nettype wire
